@@ sv/swz_pkg.sv @@
// Shared types and constants for the sliding-window z-score detector.
package swz_pkg;

  localparam int WINDOW_MAX  = 256;
  localparam int PTR_W       = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_W     = 9;
  localparam int SUM_W       = 24;
  localparam int SQ_W        = 39;
  localparam int THR_W       = 16;
  localparam int CHAN_W      = 3;
  localparam int CFG_W       = 16;
  localparam int IDX_W       = 2;
  localparam int MIN_COUNT   = 3;

  localparam int LEN_RESET    = 64;
  localparam int ENABLE_RESET = 1;
  localparam int THR_RESET    = 768;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_DETECT_ENABLE = 2'd1;
  localparam logic [IDX_W-1:0] REG_Z_THRESHOLD   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_UPDATE,
    ST_TEST,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [PTR_W-1:0]   wp;
    logic [COUNT_W-1:0] n;
    logic [SUM_W-1:0]   sum;
    logic [SQ_W-1:0]    sq;
  } chan_state_t;

  typedef struct packed {
    logic                   start;
    logic [COUNT_W-1:0]     n;
    logic [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]        sq;
    logic [SAMPLE_BITS-1:0] v;
    logic [THR_W-1:0]       thr;
  } ztest_req_t;

  typedef struct packed {
    logic done;
    logic anomaly;
  } ztest_rsp_t;

endpackage

@@ sv/swz_ztest.sv @@
// Multi-cycle exact z-score test: 65536*(n*v-S)^2 > t^2*(n*Q-S^2).
module swz_ztest (
  input  logic                clk,
  input  logic                rst,
  input  swz_pkg::ztest_req_t req,
  output swz_pkg::ztest_rsp_t rsp
);
  import swz_pkg::*;

  localparam int NQ_W   = COUNT_W + SQ_W;
  localparam int VAR_W  = NQ_W;
  localparam int NV_W   = COUNT_W + 1 + SAMPLE_BITS;
  localparam int D_W    = NV_W - 1;
  localparam int DD_W   = 2 * D_W;
  localparam int TT_W   = 2 * THR_W;
  localparam int HALF_W = VAR_W / 2;
  localparam int HI_W   = VAR_W - HALF_W;
  localparam int PL_W   = HALF_W + TT_W;
  localparam int PH_W   = HI_W + TT_W;
  localparam int CMP_W  = VAR_W + TT_W;
  localparam int SCALE  = 16;
  localparam int STEPS  = 5;

  logic [STEPS-1:0]     stg;
  logic [NQ_W-1:0]      nq;
  logic [NQ_W-1:0]      ss;
  logic [D_W-1:0]       d;
  logic [TT_W-1:0]      tt;
  logic [VAR_W-1:0]     var_r;
  logic [DD_W-1:0]      dd;
  logic [PL_W-1:0]      p_lo;
  logic [PH_W-1:0]      p_hi;
  logic                 anomaly_r;

  logic [SUM_W-1:0]     s_abs;
  logic signed [NV_W-1:0] nv_diff;
  logic [D_W-1:0]       d_abs;
  logic [CMP_W-1:0]     lhs;
  logic [CMP_W-1:0]     rhs;

  assign s_abs   = req.sum[SUM_W-1] ? SUM_W'(SUM_W'(0) - req.sum) : req.sum;
  assign nv_diff = $signed({1'b0, req.n}) * $signed(req.v) - NV_W'($signed(req.sum));
  assign d_abs   = nv_diff[NV_W-1] ? D_W'(-nv_diff) : D_W'(nv_diff);

  assign lhs = CMP_W'({dd, SCALE'(0)});
  assign rhs = CMP_W'({p_hi, HALF_W'(0)}) + CMP_W'(p_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= '0;
    end else begin
      stg <= {stg[STEPS-2:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      nq <= req.n * req.sq;
      ss <= s_abs * s_abs;
      d  <= d_abs;
      tt <= req.thr * req.thr;
    end
    if (stg[0]) begin
      var_r <= nq - ss;
      dd    <= d * d;
    end
    if (stg[1]) begin
      p_lo <= var_r[HALF_W-1:0] * tt;
    end
    if (stg[2]) begin
      p_hi <= var_r[VAR_W-1:HALF_W] * tt;
    end
    if (stg[3]) begin
      anomaly_r <= (var_r != '0) && (lhs > rhs);
    end
  end

  assign rsp.done    = stg[STEPS-1];
  assign rsp.anomaly = anomaly_r;

endmodule

@@ sv/sliding_window_zscore_detector_unit.sv @@
// Top level: per-channel sliding window with running sums and z-score flagging.
//
//   channel  handshake             payload
//   cfg      cfg_we                cfg_index, cfg_data
//   in       in_valid / in_ready   func, channel, sample
//   out      out_valid / out_ready anomaly, out_channel, sample_count, window_sum,
//                                  window_sum_sq
//
// One item at a time. A record beat with detection runs state read, ring read,
// update/write-back, then the 5-step shared test unit. Records with detection
// off or fewer than 3 samples skip the test; clear and unimplemented channels
// go straight to the output state. Reset restores the registers and marks all
// channel states empty; the sample ring needs no clearing. A stalled output
// holds the next result in its final state until the register frees up.
module sliding_window_zscore_detector_unit #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [swz_pkg::IDX_W-1:0]                cfg_index,
  input  logic [swz_pkg::CFG_W-1:0]                cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     func,
  input  logic [swz_pkg::CHAN_W-1:0]               channel,
  input  logic signed [swz_pkg::SAMPLE_BITS-1:0]   sample,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     anomaly,
  output logic [swz_pkg::CHAN_W-1:0]               out_channel,
  output logic [swz_pkg::COUNT_W-1:0]              sample_count,
  output logic signed [swz_pkg::SUM_W-1:0]         window_sum,
  output logic [swz_pkg::SQ_W-1:0]                 window_sum_sq
);
  import swz_pkg::*;

  localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHX_W      = CH_W + CHAN_W;
  localparam int RING_DEPTH = NUM_CHANNELS * WINDOW_MAX;
  localparam int RING_AW    = CH_W + PTR_W;
  localparam int VSQ_W      = 2 * SAMPLE_BITS;

  // configuration
  logic [COUNT_W-1:0] window_length;
  logic               detect_enable;
  logic [THR_W-1:0]   z_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= COUNT_W'(LEN_RESET);
      detect_enable <= 1'(ENABLE_RESET);
      z_threshold   <= THR_W'(THR_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[COUNT_W-1:0];
        REG_DETECT_ENABLE: detect_enable <= cfg_data[0];
        REG_Z_THRESHOLD:   z_threshold   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COUNT_W-1:0] len_eff;
  always_comb begin
    priority if (window_length == '0) begin
      len_eff = COUNT_W'(1);
    end else if (window_length > COUNT_W'(WINDOW_MAX)) begin
      len_eff = COUNT_W'(WINDOW_MAX);
    end else begin
      len_eff = window_length;
    end
  end

  // control
  state_t state, state_next;
  logic   in_beat;
  logic   st_rd_en;
  logic   st_we;
  logic   ring_re;
  logic   out_load;
  logic   test_start;
  ztest_req_t zreq;
  ztest_rsp_t zrsp;

  logic [CHX_W-1:0] chx;
  logic [CH_W-1:0]  in_ch_idx;
  logic             in_ch_ok;

  assign chx       = CHX_W'(channel);
  assign in_ch_idx = chx[CH_W-1:0];
  assign in_ch_ok  = chx < CHX_W'(NUM_CHANNELS);
  assign in_beat   = in_valid && in_ready;

  // item and result registers
  logic [CHAN_W-1:0]             cur_ch;
  logic [CH_W-1:0]               cur_idx;
  logic signed [SAMPLE_BITS-1:0] cur_v;
  logic [VSQ_W-1:0]              v_sq;
  logic [COUNT_W-1:0]            res_cnt;
  logic [SUM_W-1:0]              res_sum;
  logic [SQ_W-1:0]               res_sq;
  logic                          res_anom;

  // channel state memory
  chan_state_t              st_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  st_vld;
  chan_state_t              st_rd;
  logic                     st_rd_vld;
  chan_state_t              cur;
  chan_state_t              st_wdata;

  // sample ring memory
  logic signed [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ring_rd;
  logic [RING_AW-1:0]            ring_raddr;
  logic [RING_AW-1:0]            ring_waddr;

  assign cur        = st_rd_vld ? st_rd : '0;
  assign ring_raddr = {cur_idx, PTR_W'(cur.wp - cur.n[PTR_W-1:0])};
  assign ring_waddr = {cur_idx, cur.wp};

  // window update
  logic [SAMPLE_BITS-1:0] v_abs;
  logic [SAMPLE_BITS-1:0] old_abs;
  logic [VSQ_W-1:0]       old_sq;
  logic                   evict;
  logic [COUNT_W-1:0]     n_new;
  logic [SUM_W-1:0]       s_new;
  logic [SQ_W-1:0]        q_new;

  assign v_abs   = cur_v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-cur_v) : cur_v;
  assign old_abs = ring_rd[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ring_rd) : ring_rd;
  assign old_sq  = old_abs * old_abs;
  assign evict   = cur.n >= len_eff;
  assign n_new   = evict ? cur.n : COUNT_W'(cur.n + 1'b1);
  assign s_new   = cur.sum + SUM_W'(cur_v) - (evict ? SUM_W'(ring_rd) : '0);
  assign q_new   = cur.sq + SQ_W'(v_sq) - (evict ? SQ_W'(old_sq) : '0);

  always_comb begin
    st_wdata.wp  = PTR_W'(cur.wp + 1'b1);
    st_wdata.n   = n_new;
    st_wdata.sum = s_new;
    st_wdata.sq  = q_new;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (func == FUNC_CLEAR || !in_ch_ok) ? ST_OUT : ST_RING;
        end
      end
      ST_RING:   state_next = ST_UPDATE;
      ST_UPDATE: begin
        state_next = (detect_enable && n_new >= COUNT_W'(MIN_COUNT)) ? ST_TEST : ST_OUT;
      end
      ST_TEST:   state_next = ST_WAIT;
      ST_WAIT: begin
        if (zrsp.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    ring_re    = 1'b0;
    st_we      = 1'b0;
    out_load   = 1'b0;
    test_start = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready   = 1'b1;
      ST_RING:   ring_re    = 1'b1;
      ST_UPDATE: st_we      = 1'b1;
      ST_TEST:   test_start = 1'b1;
      ST_WAIT:   ;
      ST_OUT:    out_load   = !out_valid || out_ready;
      default:   ;
    endcase
  end

  assign st_rd_en   = in_beat;
  assign zreq.start = test_start;
  assign zreq.n     = res_cnt;
  assign zreq.sum   = res_sum;
  assign zreq.sq    = res_sq;
  assign zreq.v     = cur_v;
  assign zreq.thr   = z_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (in_beat && func == FUNC_CLEAR) begin
      st_vld <= '0;
    end else if (st_we) begin
      st_vld[cur_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[cur_idx] <= st_wdata;
    end
    if (st_rd_en) begin
      st_rd     <= st_mem[in_ch_idx];
      st_rd_vld <= st_vld[in_ch_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      ring_mem[ring_waddr] <= cur_v;
    end
    if (ring_re) begin
      ring_rd <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_ch   <= channel;
      cur_idx  <= in_ch_idx;
      cur_v    <= sample;
      res_cnt  <= '0;
      res_sum  <= '0;
      res_sq   <= '0;
      res_anom <= 1'b0;
    end
    if (ring_re) begin
      v_sq <= v_abs * v_abs;
    end
    if (st_we) begin
      res_cnt <= n_new;
      res_sum <= s_new;
      res_sq  <= q_new;
    end
    if (zrsp.done) begin
      res_anom <= zrsp.anomaly;
    end
  end

  swz_ztest u_ztest (
    .clk (clk),
    .rst (rst),
    .req (zreq),
    .rsp (zrsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      anomaly       <= res_anom;
      out_channel   <= cur_ch;
      sample_count  <= res_cnt;
      window_sum    <= res_sum;
      window_sum_sq <= res_sq;
    end
  end

endmodule

@@ sv/swz_checker.sv @@
// Port-level checks for the z-score detector, bound to the top level.
module swz_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              anomaly,
  input logic [swz_pkg::CHAN_W-1:0]        out_channel,
  input logic [swz_pkg::COUNT_W-1:0]       sample_count,
  input logic signed [swz_pkg::SUM_W-1:0]  window_sum,
  input logic [swz_pkg::SQ_W-1:0]          window_sum_sq
);
  import swz_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(anomaly) && $stable(out_channel)
      && $stable(sample_count) && $stable(window_sum) && $stable(window_sum_sq))
    else $error("result beat changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_few_samples: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count < COUNT_W'(MIN_COUNT) |-> !anomaly)
    else $error("anomaly flagged on a short window");

  a_empty_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count == '0 |-> window_sum == '0 && window_sum_sq == '0)
    else $error("empty window with nonzero sums");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind sliding_window_zscore_detector_unit swz_checker u_swz_checker (.*);
